[sv/salc_pkg.sv]
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants of the set-associative LRU cache directory.
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int unsigned AddrW       = 32;
  localparam int unsigned DataW       = 32;
  localparam int unsigned WayW        = 5;
  localparam int unsigned DefWays     = 32;
  localparam int unsigned DefSetBits  = 4;
  localparam int unsigned DefOffBits  = 4;
  localparam int unsigned InTdataW    = 96;
  localparam int unsigned OutTdataW   = 40;

  localparam logic CmdRead  = 1'b0;
  localparam logic CmdWrite = 1'b1;

  typedef struct packed {
    logic             hit;
    logic [WayW-1:0]  way;
    logic [DataW-1:0] rdata;
    logic             mem_write;
  } res_t;

endpackage

[sv/salc_set_update.sv]
// ----------------------------------------------------------------------------
// salc_set_update
// Tag match, victim choice, line update and LRU reordering of one set row.
// ----------------------------------------------------------------------------
module salc_set_update #(
  parameter int unsigned WAYS  = salc_pkg::DefWays,
  parameter int unsigned TAG_W = 24
) (
  input  logic [WAYS*TAG_W-1:0]            tags_i,
  input  logic [WAYS*salc_pkg::DataW-1:0]  words_i,
  input  logic [WAYS-1:0]                  valid_i,
  input  logic [WAYS*salc_pkg::WayW-1:0]   ages_i,
  input  logic [TAG_W-1:0]                 tag_i,
  input  logic                             cmd_i,
  input  logic [salc_pkg::DataW-1:0]       wdata_i,
  input  logic [salc_pkg::DataW-1:0]       fdata_i,
  output logic [WAYS*TAG_W-1:0]            tags_o,
  output logic [WAYS*salc_pkg::DataW-1:0]  words_o,
  output logic [WAYS-1:0]                  valid_o,
  output logic [WAYS*salc_pkg::WayW-1:0]   ages_o,
  output salc_pkg::res_t                   res_o
);

  localparam int unsigned WW = salc_pkg::WayW;
  localparam int unsigned DW = salc_pkg::DataW;

  logic                 hit;
  logic [WW-1:0]        way;
  logic [DW-1:0]        rword;
  logic [WW-1:0]        pos;
  logic                 found;
  logic                 is_wr;

  always_comb begin
    is_wr = (cmd_i == salc_pkg::CmdWrite);
    hit   = 1'b0;
    way   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (valid_i[w] && (tags_i[w*TAG_W +: TAG_W] == tag_i)) begin
        hit = 1'b1;
        way = WW'(w);
      end
    end
    if (!hit) begin
      way = ages_i[WW-1:0];
    end

    tags_o  = tags_i;
    words_o = words_i;
    valid_o = valid_i;
    rword   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (way == WW'(w)) begin
        rword      = words_i[w*DW +: DW];
        valid_o[w] = 1'b1;
        if (!hit) begin
          tags_o[w*TAG_W +: TAG_W] = tag_i;
        end
        if (is_wr || !hit) begin
          words_o[w*DW +: DW] = is_wr ? wdata_i : fdata_i;
        end
      end
    end

    pos   = WW'(WAYS - 1);
    found = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      if (!found && (ages_i[i*WW +: WW] == way)) begin
        pos   = WW'(i);
        found = 1'b1;
      end
    end
    ages_o = ages_i;
    for (int i = 0; i < WAYS; i++) begin
      if (WW'(i) >= pos) begin
        if (i < WAYS - 1) begin
          ages_o[i*WW +: WW] = ages_i[((i + 1) % WAYS)*WW +: WW];
        end else begin
          ages_o[i*WW +: WW] = way;
        end
      end
    end

    res_o.hit       = hit;
    res_o.way       = way;
    res_o.rdata     = is_wr ? '0 : (hit ? rword : fdata_i);
    res_o.mem_write = is_wr;
  end

endmodule

[sv/set_assoc_lru_cache.sv]
// ----------------------------------------------------------------------------
// set_assoc_lru_cache
// Set-associative, write-allocate, write-through cache directory with LRU.
// ----------------------------------------------------------------------------
// A transaction on the slave stream carries one access: tuser is the command
// (read or write), tdata holds the address, the write word and the word that
// memory holds at that address. Each access gives exactly one transaction on
// the master stream with the hit flag, the way used, the read word and the
// memory write flag.
// Each set lives in one row of two synchronous memories (the line words, and
// the tags with the valid bits and the LRU order). An access reads its row in
// the cycle it is taken and writes the updated row back in the next cycle,
// where the result is loaded into the output register. The next access is
// taken only after the write-back, so no two accesses touch a row at once.
// After reset a clearing pass writes every set's valid bits and LRU order,
// one set per cycle; no access is taken meanwhile.
// When the receiver stalls, the result waits in the output register and the
// next access is taken once the register drains.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache #(
  parameter int unsigned WAYS        = salc_pkg::DefWays,
  parameter int unsigned SET_BITS    = salc_pkg::DefSetBits,
  parameter int unsigned OFFSET_BITS = salc_pkg::DefOffBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // tdata: address [31:0], write_data [63:32], fill_data [95:64]
  input  logic [salc_pkg::InTdataW-1:0]   s_axis_tdata_i,
  // tuser: command
  input  logic                            s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // tdata: way_used [4:0], read_data [36:5], zero padding [39:37]
  output logic [salc_pkg::OutTdataW-1:0]  m_axis_tdata_o,
  // tuser: hit [0], memory_write [1]
  output logic [1:0]                      m_axis_tuser_o
);

  localparam int unsigned SETS  = 1 << SET_BITS;
  localparam int unsigned TAG_W = salc_pkg::AddrW - SET_BITS - OFFSET_BITS;
  localparam int unsigned WW    = salc_pkg::WayW;
  localparam int unsigned DW    = salc_pkg::DataW;
  localparam int unsigned META_W = WAYS + WAYS * WW;
  localparam int unsigned TAGS_W = WAYS * TAG_W;
  localparam int unsigned DIR_W  = TAGS_W + META_W;

  localparam logic [1:0] StClear  = 2'd0;
  localparam logic [1:0] StIdle   = 2'd1;
  localparam logic [1:0] StLookup = 2'd2;

  logic [DIR_W-1:0]      dir_mem  [SETS];
  logic [WAYS*DW-1:0]    word_mem [SETS];

  logic [1:0]            state_q, state_d;
  logic [SET_BITS:0]     clr_q, clr_d;
  logic [SET_BITS-1:0]   set_q;
  logic [TAG_W-1:0]      tag_q;
  logic                  cmd_q;
  logic [DW-1:0]         wdata_q;
  logic [DW-1:0]         fdata_q;
  logic [DIR_W-1:0]      dir_rd_q;
  logic [WAYS*DW-1:0]    word_rd_q;
  logic                  out_valid_q;
  salc_pkg::res_t        out_q;

  logic                  in_acc;
  logic [SET_BITS-1:0]   in_set;
  logic [WAYS*TAG_W-1:0] tags_new;
  logic [WAYS*DW-1:0]    words_new;
  logic [WAYS-1:0]       valid_new;
  logic [WAYS*WW-1:0]    ages_new;
  logic [META_W-1:0]     meta_init;
  salc_pkg::res_t        res;

  assign s_axis_tready_o = (state_q == StIdle) && (!out_valid_q || m_axis_tready_i);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign in_set = s_axis_tdata_i[OFFSET_BITS +: SET_BITS];

  always_comb begin
    meta_init = '0;
    for (int w = 0; w < WAYS; w++) begin
      meta_init[WAYS + w*WW +: WW] = WW'(w);
    end
  end

  salc_set_update #(
    .WAYS  (WAYS),
    .TAG_W (TAG_W)
  ) u_update (
    .tags_i  (dir_rd_q[TAGS_W-1:0]),
    .words_i (word_rd_q),
    .valid_i (dir_rd_q[TAGS_W +: WAYS]),
    .ages_i  (dir_rd_q[DIR_W-1:TAGS_W+WAYS]),
    .tag_i   (tag_q),
    .cmd_i   (cmd_q),
    .wdata_i (wdata_q),
    .fdata_i (fdata_q),
    .tags_o  (tags_new),
    .words_o (words_new),
    .valid_o (valid_new),
    .ages_o  (ages_new),
    .res_o   (res)
  );

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      StClear: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == (SET_BITS + 1)'(SETS - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_acc) begin
          state_d = StLookup;
        end
      end
      StLookup: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (state_q == StLookup) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      set_q   <= in_set;
      tag_q   <= s_axis_tdata_i[OFFSET_BITS + SET_BITS +: TAG_W];
      cmd_q   <= s_axis_tuser_i;
      wdata_q <= s_axis_tdata_i[DW +: DW];
      fdata_q <= s_axis_tdata_i[2*DW +: DW];
    end
    if (state_q == StLookup) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    dir_rd_q  <= dir_mem[in_set];
    word_rd_q <= word_mem[in_set];
    if (state_q == StClear) begin
      dir_mem[clr_q[SET_BITS-1:0]] <= {meta_init, {TAGS_W{1'b0}}};
    end else if (state_q == StLookup) begin
      dir_mem[set_q]  <= {ages_new, valid_new, tags_new};
      word_mem[set_q] <= words_new;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_q.rdata, out_q.way};
  assign m_axis_tuser_o  = {out_q.mem_write, out_q.hit};

`ifndef ASSERT_OFF
  a_no_accept_in_clear: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (state_q == StClear) |-> !s_axis_tready_o
  ) else $error("access taken during clearing pass");

  a_accept_to_lookup: assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_acc |=> (state_q == StLookup)
  ) else $error("accepted access not looked up");

  a_lookup_loads_out: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (state_q == StLookup) |=> m_axis_tvalid_o
  ) else $error("lookup gave no result");
`endif

endmodule
